@@ hdl/prv_pkg.sv @@
// Shared types and constants of the page replacement victim selector.
package prv_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_POLICY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAMES   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WS_WIN   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_NRU_INTV = 2'd3;

  localparam logic [2:0] POL_FIFO   = 3'd0;
  localparam logic [2:0] POL_RANDOM = 3'd1;
  localparam logic [2:0] POL_CLOCK  = 3'd2;
  localparam logic [2:0] POL_NRU    = 3'd3;
  localparam logic [2:0] POL_AGING  = 3'd4;
  localparam logic [2:0] POL_WSET   = 3'd5;

  localparam logic [1:0] MODE_ACCESS  = 2'd0;
  localparam logic [1:0] MODE_MAP     = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_SELECT  = 2'd3;

  localparam logic [7:0]  FRAMES_RST = 8'd16;
  localparam logic [15:0] WIN_RST    = 16'd50;
  localparam logic [15:0] INTV_RST   = 16'd50;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FINISH,
    ST_DONE
  } state_e;

endpackage

@@ hdl/prv_if.sv @@
// Handshake channels for the request items and the result items.
interface prv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  frame;
  logic        is_write;
  logic [31:0] current_time;
  logic [30:0] random_word;

  modport source (output valid, mode, frame, is_write, current_time, random_word,
                  input ready);
  modport sink (input valid, mode, frame, is_write, current_time, random_word,
                output ready);
endinterface

interface prv_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] victim_frame;
  logic       victim_valid;
  logic       victim_modified;

  modport source (output valid, victim_frame, victim_valid, victim_modified,
                  input ready);
  modport sink (input valid, victim_frame, victim_valid, victim_modified,
                output ready);
endinterface

@@ hdl/prv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module prv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/prv_mod_unit.sv @@
// Bit-serial restoring remainder unit: a 32-bit dividend modulo a small divisor.
module prv_mod_unit #(
  parameter int unsigned NW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] rem_o
);

  logic [31:0]   dvd_q;
  logic [NW-1:0] rem_q;
  logic [4:0]    cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [NW:0]   trial;
  logic [NW:0]   dsr;
  logic [NW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[31]};
    dsr   = {1'b0, divisor_i};
    if (trial >= dsr) begin
      rem_d = NW'(trial - dsr);
    end else begin
      rem_d = NW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/page_replacement_victim_select.sv @@
// Frame replacement engine. Access, map and release items go from idle straight
// to the done state. A select item first reduces the hand (or the random word)
// modulo the frame count in a bit-serial remainder unit, then, for clock, NRU,
// aging and working set, scans the frames, each through a read state and an
// evaluation state, because the age and last-use memories have a registered
// read. After reset a clearing pass over all FRAMES addresses zeroes both
// memories before the first item is taken.
module page_replacement_victim_select #(
  parameter int unsigned FRAMES = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [prv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [prv_pkg::CfgDataW-1:0] cfg_data_i,
  prv_req_if.sink                    req_i,
  prv_rsp_if.source                  rsp_o
);
  import prv_pkg::*;

  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned NW = $clog2(FRAMES + 1);

  state_e state_q, state_d;

  logic [2:0]  policy_q;
  logic [7:0]  fiu_q;
  logic [15:0] win_q;
  logic [15:0] intv_q;

  logic [FRAMES-1:0] ref_q;
  logic [FRAMES-1:0] mod_q;
  logic [NW-1:0]     hand_q;
  logic [31:0]       nru_last_q;

  logic [NW-1:0] clr_cnt_q;
  logic [1:0]    mode_q;
  logic [31:0]   now_q;
  logic [FW-1:0] h_q, ind_q, cnt_q, idx_q;
  logic [2:0]    best_q;
  logic [31:0]   least_q, oldest_q;
  logic          first_q;

  logic       out_valid_q;
  logic [6:0] out_frame_q;
  logic       out_vv_q;
  logic       out_mod_q;

  logic [31:0]   n32;
  logic [NW-1:0] n;
  logic          acc, load_out, frame_ok;
  logic [FW-1:0] req_idx;

  logic          mod_start, mod_done;
  logic [31:0]   mod_dvd;
  logic [NW-1:0] mod_rem;

  logic          age_we, last_we;
  logic [FW-1:0] age_wa, last_wa;
  logic [31:0]   age_wd, last_wd, age_rd, last_rd;

  logic          cur_ref, cur_mod;
  logic [31:0]   age_new, idle;
  logic          last_step, scan_stop, scan_upd, ref_clr;
  logic [FW-1:0] ind_nxt, scan_vic;
  logic [2:0]    cls;
  logic [31:0]   vic32, nru_diff;
  logic [32:0]   nru_span;

  // Frame count clamped to 1 .. FRAMES.
  always_comb begin
    if (fiu_q == 8'd0) begin
      n32 = 32'd1;
    end else if (32'(fiu_q) > 32'(FRAMES)) begin
      n32 = 32'(FRAMES);
    end else begin
      n32 = 32'(fiu_q);
    end
    n = n32[NW-1:0];
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  assign frame_ok    = 32'(req_i.frame) < 32'(FRAMES);
  assign req_idx     = FW'(req_i.frame);

  assign mod_start = acc && (req_i.mode == MODE_SELECT);
  assign mod_dvd   = (policy_q == POL_RANDOM) ? {1'b0, req_i.random_word} : 32'(hand_q);

  prv_mod_unit #(.NW(NW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (n),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Evaluation of the frame at the scan position.
  always_comb begin
    cur_ref   = ref_q[ind_q];
    cur_mod   = mod_q[ind_q];
    age_new   = {cur_ref, age_rd[31:1]};
    idle      = now_q - last_rd;
    last_step = (32'(cnt_q) + 32'd1) == n32;
    ind_nxt   = ((32'(ind_q) + 32'd1) == n32) ? '0 : FW'(32'(ind_q) + 32'd1);
    cls       = {1'b0, cur_ref, cur_mod};
    scan_stop = last_step;
    scan_upd  = 1'b0;
    ref_clr   = 1'b0;
    scan_vic  = idx_q;
    case (policy_q)
      POL_CLOCK: begin
        if (!cur_ref) begin
          scan_stop = 1'b1;
          scan_vic  = ind_q;
        end else begin
          ref_clr  = 1'b1;
          scan_vic = h_q;
        end
      end
      POL_NRU: begin
        scan_upd = cls < best_q;
        if (scan_upd) begin
          scan_vic = ind_q;
          if (cls == 3'd0) begin
            scan_stop = 1'b1;
          end
        end
      end
      POL_AGING: begin
        ref_clr  = 1'b1;
        scan_upd = first_q || (age_new < least_q);
        if (scan_upd) begin
          scan_vic = ind_q;
        end
      end
      POL_WSET: begin
        if (!cur_ref && (idle >= 32'(win_q))) begin
          scan_stop = 1'b1;
          scan_vic  = ind_q;
        end else if (cur_ref) begin
          ref_clr = 1'b1;
        end else if (idle > oldest_q) begin
          scan_upd = 1'b1;
          scan_vic = ind_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory write ports: clearing pass, map and release, scan write-back.
  always_comb begin
    age_we  = 1'b0;
    last_we = 1'b0;
    age_wa  = req_idx;
    last_wa = req_idx;
    age_wd  = '0;
    last_wd = '0;
    case (state_q)
      ST_CLEAR: begin
        age_we  = 1'b1;
        last_we = 1'b1;
        age_wa  = clr_cnt_q[FW-1:0];
        last_wa = clr_cnt_q[FW-1:0];
      end
      ST_IDLE: begin
        if (acc && frame_ok &&
            (req_i.mode == MODE_MAP || req_i.mode == MODE_RELEASE)) begin
          age_we  = 1'b1;
          last_we = 1'b1;
          last_wd = (req_i.mode == MODE_MAP) ? req_i.current_time : '0;
        end
      end
      ST_SCAN_EV: begin
        age_wa  = ind_q;
        last_wa = ind_q;
        age_wd  = age_new;
        last_wd = now_q;
        age_we  = (policy_q == POL_AGING);
        last_we = (policy_q == POL_WSET) && cur_ref;
      end
      default: begin
      end
    endcase
  end

  prv_ram #(.Width(32), .Depth(FRAMES)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (age_wa),
    .wdata_i (age_wd),
    .raddr_i (ind_q),
    .rdata_o (age_rd)
  );

  prv_ram #(.Width(32), .Depth(FRAMES)) u_last_ram (
    .clk_i   (clk_i),
    .we_i    (last_we),
    .waddr_i (last_wa),
    .wdata_i (last_wd),
    .raddr_i (ind_q),
    .rdata_o (last_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (32'(clr_cnt_q) == 32'(FRAMES) - 32'd1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          state_d = (req_i.mode == MODE_SELECT) ? ST_MOD : ST_DONE;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          if (policy_q == POL_CLOCK || policy_q == POL_NRU ||
              policy_q == POL_AGING || policy_q == POL_WSET) begin
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: state_d = scan_stop ? ST_FINISH : ST_SCAN_RD;
      ST_FINISH:  state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
      fiu_q    <= FRAMES_RST;
      win_q    <= WIN_RST;
      intv_q   <= INTV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY:   policy_q <= cfg_data_i[2:0];
        CFG_FRAMES:   fiu_q    <= cfg_data_i[7:0];
        CFG_WS_WIN:   win_q    <= cfg_data_i;
        CFG_NRU_INTV: intv_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign vic32    = 32'(idx_q);
  assign nru_diff = now_q - nru_last_q;
  assign nru_span = {1'b0, nru_diff} + 33'd1;

  // Per-frame bits, hand, the NRU clearing mark, clearing counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= '0;
      mod_q       <= '0;
      hand_q      <= '0;
      nru_last_q  <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (acc && frame_ok) begin
        case (req_i.mode)
          MODE_ACCESS: begin
            ref_q[req_idx] <= 1'b1;
            if (req_i.is_write) begin
              mod_q[req_idx] <= 1'b1;
            end
          end
          MODE_MAP: begin
            ref_q[req_idx] <= 1'b1;
            mod_q[req_idx] <= req_i.is_write;
          end
          MODE_RELEASE: begin
            ref_q[req_idx] <= 1'b0;
            mod_q[req_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state_q == ST_SCAN_EV && ref_clr) begin
        ref_q[ind_q] <= 1'b0;
      end
      if (state_q == ST_FINISH) begin
        case (policy_q)
          POL_RANDOM: begin
          end
          POL_CLOCK, POL_NRU, POL_AGING, POL_WSET: begin
            hand_q <= NW'(vic32 + 32'd1);
            if (policy_q == POL_NRU && nru_span >= 33'(intv_q)) begin
              nru_last_q <= now_q + 32'd1;
              ref_q      <= '0;
            end
          end
          default: begin
            hand_q <= ((32'(h_q) + 32'd1) == n32) ? '0 : NW'(32'(h_q) + 32'd1);
          end
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan registers, the latched item and the output registers.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      mode_q <= req_i.mode;
      now_q  <= req_i.current_time;
    end
    if (state_q == ST_MOD && mod_done) begin
      h_q      <= FW'(mod_rem);
      ind_q    <= FW'(mod_rem);
      idx_q    <= FW'(mod_rem);
      cnt_q    <= '0;
      best_q   <= 3'd4;
      least_q  <= '0;
      oldest_q <= '0;
      first_q  <= 1'b1;
    end
    if (state_q == ST_SCAN_EV) begin
      idx_q   <= scan_vic;
      ind_q   <= ind_nxt;
      cnt_q   <= cnt_q + 1'b1;
      first_q <= 1'b0;
      if (scan_upd) begin
        best_q   <= cls;
        least_q  <= age_new;
        oldest_q <= idle;
      end
    end
    if (load_out) begin
      if (mode_q == MODE_SELECT) begin
        out_frame_q <= vic32[6:0];
        out_vv_q    <= 1'b1;
        out_mod_q   <= mod_q[idx_q];
      end else begin
        out_frame_q <= '0;
        out_vv_q    <= 1'b0;
        out_mod_q   <= 1'b0;
      end
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.victim_frame    = out_frame_q;
  assign rsp_o.victim_valid    = out_vv_q;
  assign rsp_o.victim_modified = out_mod_q;

endmodule
